// File: sv/assert_macros.svh
// Assertion macros for the checker file of the encoder, rse_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define RSE_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("encoder assertion failed");

// Same, on the block's own clock and reset.
`define RSE_ASSERT(lbl, prop) `RSE_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// File: sv/rse_pkg.sv
// Package for the Reed-Solomon encoder: widths, field constants, GF(2^8) helpers.
// No dependencies.
`default_nettype none

package rse_pkg;

    localparam int RSE_SYM_W          = 8;
    localparam int RSE_CFG_W          = 6;
    localparam int RSE_MAX_PARITY_DEF = 32;

    localparam logic [RSE_CFG_W-1:0] RSE_RESET_PARITY = 6'd16;
    localparam logic [8:0]           RSE_FIELD_POLY   = 9'h11D;
    localparam logic [7:0]           RSE_FIELD_ORDER  = 8'd255;

    // Multiply by the primitive element 2.
    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? RSE_FIELD_POLY[7:0] : 8'h00);
    endfunction

    // Full GF(2^8) multiply, shift-and-add over the bits of b.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = a;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            x = xtime(x);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/rse_in_if.sv
// Input channel of the encoder: valid/ready with one message byte per beat.
// Depends on rse_pkg.
`default_nettype none

interface rse_in_if
    import rse_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [RSE_SYM_W-1:0] data_byte;
    logic                 block_end;

    modport source(output valid, output data_byte, output block_end, input ready);
    modport sink(input valid, input data_byte, input block_end, output ready);
endinterface

`default_nettype wire

// File: sv/rse_out_if.sv
// Output channel of the encoder: valid/ready with one data or parity byte per beat.
// Depends on rse_pkg.
`default_nettype none

interface rse_out_if
    import rse_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [RSE_SYM_W-1:0] out_byte;
    logic                 is_parity;
    logic                 run_last;
    logic                 too_long;

    modport source(output valid, output out_byte, output is_parity, output run_last,
                   output too_long, input ready);
    modport sink(input valid, input out_byte, input is_parity, input run_last,
                 input too_long, output ready);
endinterface

`default_nettype wire

// File: sv/rse_gen.sv
// Generator polynomial builder: multiplies in one (x + 2^i) factor per cycle.
// Depends on rse_pkg (gf_mul, xtime).
`default_nettype none

module rse_gen
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = RSE_MAX_PARITY_DEF,
    parameter int NW         = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [NW-1:0]                        i_n,
    output logic      [MAX_PARITY-1:0][RSE_SYM_W-1:0] o_gen,
    output logic                                      o_busy
);

    logic                                 r_pend;
    logic [NW-1:0]                        r_left;
    logic [RSE_SYM_W-1:0]                 r_root;
    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] r_gen;
    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] n_gen;

    // Coefficients above the current degree are zero, so every tap updates alike.
    always_comb begin
        n_gen[0] = r_gen[0] ^ r_root;
        for (int j = 1; j < MAX_PARITY; j++) begin
            n_gen[j] = r_gen[j] ^ gf_mul(r_root, r_gen[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b1;
            r_left <= '0;
        end else if (i_start) begin
            r_pend <= 1'b1;
        end else if (r_pend) begin
            r_pend <= 1'b0;
            r_left <= i_n;
        end else if (r_left != '0) begin
            r_left <= r_left - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_gen  <= '0;
            r_root <= 8'h01;
        end else if (r_left != '0) begin
            r_gen  <= n_gen;
            r_root <= xtime(r_root);
        end
    end

    assign o_gen  = r_gen;
    assign o_busy = r_pend || (r_left != '0);

endmodule

`default_nettype wire

// File: sv/rse_lfsr.sv
// Remainder register, byte counter and overflow flag; one division step per beat.
// Depends on rse_pkg (gf_mul, field constants).
`default_nettype none

module rse_lfsr
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = RSE_MAX_PARITY_DEF,
    parameter int NW         = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_clear,
    input  wire logic                                 i_accept,
    input  wire logic [RSE_SYM_W-1:0]                 i_data_byte,
    input  wire logic                                 i_block_end,
    input  wire logic [NW-1:0]                        i_n,
    input  wire logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] i_gen,
    output logic      [MAX_PARITY-1:0][RSE_SYM_W-1:0] o_par,
    output logic                                      o_too_long
);

    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] r_rem;
    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] n_rem;
    logic [7:0]                           r_count;
    logic [7:0]                           n_count;
    logic                                 r_flag;
    logic                                 n_flag;
    logic [RSE_SYM_W-1:0]                 fb;

    always_comb begin
        fb = i_data_byte ^ r_rem[0];
        for (int j = 0; j < MAX_PARITY; j++) begin
            if ((j + 1 < MAX_PARITY) && ((NW+1)'(j + 1) < {1'b0, i_n})) begin
                n_rem[j] = r_rem[(j + 1) % MAX_PARITY] ^ gf_mul(fb, i_gen[j]);
            end else begin
                n_rem[j] = gf_mul(fb, i_gen[j]);
            end
        end
        n_count = (r_count != RSE_FIELD_ORDER) ? r_count + 8'd1 : r_count;
        n_flag  = r_flag || (n_count > (RSE_FIELD_ORDER - 8'(i_n)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || (i_accept && i_block_end)) begin
            r_rem   <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_accept) begin
            r_rem   <= n_rem;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    assign o_par      = n_rem;
    assign o_too_long = n_flag;

endmodule

`default_nettype wire

// File: sv/rse_out.sv
// Result register and parity shifter; drives the output channel.
// Depends on rse_pkg and rse_out_if.
`default_nettype none

module rse_out
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = RSE_MAX_PARITY_DEF,
    parameter int NW         = $clog2(MAX_PARITY + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_load,
    input  wire logic [RSE_SYM_W-1:0]                 i_data_byte,
    input  wire logic                                 i_block_end,
    input  wire logic                                 i_too_long,
    input  wire logic [NW-1:0]                        i_n,
    input  wire logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] i_par,
    output logic                                      o_can_take,
    rse_out_if.source                                 o_res
);

    logic                                 r_valid;
    logic [RSE_SYM_W-1:0]                 r_byte;
    logic                                 r_is_parity;
    logic                                 r_run_last;
    logic                                 r_too_long;
    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] r_par;
    logic [NW-1:0]                        r_left;
    logic                                 r_par_flag;
    logic                                 slot_free;
    logic                                 emit_par;

    assign slot_free  = !r_valid || o_res.ready;
    assign emit_par   = slot_free && (r_left != '0);
    assign o_can_take = slot_free && (r_left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            if (i_block_end) begin
                r_left <= i_n;
            end
        end else if (emit_par) begin
            r_valid <= 1'b1;
            r_left  <= r_left - NW'(1);
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte      <= i_data_byte;
            r_is_parity <= 1'b0;
            r_run_last  <= 1'b0;
            r_too_long  <= i_too_long;
            if (i_block_end) begin
                r_par      <= i_par;
                r_par_flag <= i_too_long;
            end
        end else if (emit_par) begin
            // Pop the highest-order remaining parity symbol.
            r_byte      <= r_par[0];
            r_is_parity <= 1'b1;
            r_run_last  <= (r_left == NW'(1));
            r_too_long  <= r_par_flag;
            r_par       <= r_par >> RSE_SYM_W;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.out_byte  = r_byte;
    assign o_res.is_parity = r_is_parity;
    assign o_res.run_last  = r_run_last;
    assign o_res.too_long  = r_too_long;

endmodule

`default_nettype wire

// File: sv/reed_solomon_encoder_unit.sv
// Top level of the systematic Reed-Solomon encoder over GF(2^8), poly 0x11D.
// Depends on rse_pkg, rse_in_if, rse_out_if, rse_gen, rse_lfsr, rse_out.
`default_nettype none

// Each data byte appears on the output, unchanged, in the cycle after it is taken,
// while a MAX_PARITY-tap GF(2^8) division step updates the remainder; bytes
// may arrive back to back. The byte flagged block_end is followed by n parity
// bytes, highest order first, one per cycle while the output is not stalled, and
// no input is taken until the last of them is loaded. After reset and after
// every parity_count write the generator polynomial is rebuilt, one root per
// cycle, and the input stays not ready until the rebuild is done (n is the
// parity count, clamped to 1..MAX_PARITY). A write also starts a new block.
// too_long rises once a block holds more than 255 - n data bytes and stays set
// through that block's parity.
module reed_solomon_encoder_unit
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = RSE_MAX_PARITY_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [RSE_CFG_W-1:0] i_cfg_data,
    rse_in_if.sink                    i_data,
    rse_out_if.source                 o_res
);

    localparam int NW = $clog2(MAX_PARITY + 1);

    logic [RSE_CFG_W-1:0]                 r_parity;
    logic [NW-1:0]                        eff_n;
    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] gen;
    logic [MAX_PARITY-1:0][RSE_SYM_W-1:0] par;
    logic                                 gen_busy;
    logic                                 too_long;
    logic                                 can_take;
    logic                                 accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= RSE_RESET_PARITY;
        end else if (i_cfg_we) begin
            r_parity <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_parity == '0) begin
            eff_n = NW'(1);
        end else if ({1'b0, r_parity} > (RSE_CFG_W+1)'(MAX_PARITY)) begin
            eff_n = NW'(MAX_PARITY);
        end else begin
            eff_n = NW'(r_parity);
        end
    end

    assign i_data.ready = can_take && !gen_busy && !i_cfg_we;
    assign accept       = i_data.valid && i_data.ready;

    rse_gen #(
        .MAX_PARITY (MAX_PARITY),
        .NW         (NW)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_n     (eff_n),
        .o_gen   (gen),
        .o_busy  (gen_busy)
    );

    rse_lfsr #(
        .MAX_PARITY (MAX_PARITY),
        .NW         (NW)
    ) u_lfsr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_accept    (accept),
        .i_data_byte (i_data.data_byte),
        .i_block_end (i_data.block_end),
        .i_n         (eff_n),
        .i_gen       (gen),
        .o_par       (par),
        .o_too_long  (too_long)
    );

    rse_out #(
        .MAX_PARITY (MAX_PARITY),
        .NW         (NW)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_data_byte (i_data.data_byte),
        .i_block_end (i_data.block_end),
        .i_too_long  (too_long),
        .i_n         (eff_n),
        .i_par       (par),
        .o_can_take  (can_take),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// File: sv/rse_chk.sv
// Port-level checker for the encoder top, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rse_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cfg_we,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_end,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_parity,
    input wire logic       i_out_last
);

    // Stalled output beat holds.
    `RSE_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
    // Final-symbol marker only on parity beats.
    `RSE_ASSERT(a_last_is_par, i_out_valid && i_out_last |-> i_out_parity)
    // Parity drains before the next data beat.
    `RSE_ASSERT(a_end_blocks, i_in_valid && i_in_ready && i_in_end |=> !i_in_ready)
    // Every accepted beat, a block end's included, is shown as a data beat before its parity.
    `RSE_ASSERT(a_end_data, i_in_valid && i_in_ready |=> i_out_valid && !i_out_parity)
    // A parity-count write starts a generator rebuild.
    `RSE_ASSERT(a_cfg_busy, i_cfg_we |=> !i_in_ready)

endmodule

bind reed_solomon_encoder_unit rse_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_in_valid   (i_data.valid),
    .i_in_ready   (i_data.ready),
    .i_in_end     (i_data.block_end),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_byte   (o_res.out_byte),
    .i_out_parity (o_res.is_parity),
    .i_out_last   (o_res.run_last)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for reed_solomon_encoder_unit: stream bytes in, predict data and parity.
// Depends on rse_pkg, rse_in_if, rse_out_if and the encoder RTL.

module tb;
    import rse_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] sym;
        logic       parity;
        logic       last;
        logic       overlong;
    } t_enc_beat;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [RSE_CFG_W-1:0] cfg_data;

    rse_in_if  data_ch ();
    rse_out_if res_ch ();

    reed_solomon_encoder_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_data     (data_ch),
        .o_res      (res_ch)
    );

    // Encoder prediction state
    logic [7:0] gen_taps [RSE_MAX_PARITY_DEF];
    logic [7:0] rem_syms [RSE_MAX_PARITY_DEF];
    int         parity_n;
    int         byte_count;
    logic       overlong_flag;

    t_enc_beat  expected_beats [$];
    int         error_count = 0;
    int         quiet_cycles = 0;
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = (data_ch.valid === 1'b1) && (data_ch.ready === 1'b1);
    assign out_beat = (res_ch.valid === 1'b1) && (res_ch.ready === 1'b1);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [8:0] acc_a;
        logic [7:0] prod;
        acc_a = {1'b0, a};
        prod  = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) prod ^= acc_a[7:0];
            acc_a = {acc_a[7:0], 1'b0};
            if (acc_a[8]) acc_a ^= RSE_FIELD_POLY;
        end
        return prod;
    endfunction

    function automatic void clear_block_state();
        for (int k = 0; k < RSE_MAX_PARITY_DEF; k++) rem_syms[k] = 8'h00;
        byte_count    = 0;
        overlong_flag = 1'b0;
    endfunction

    // Product of (x + 2^i), leading 1 dropped, highest degree first.
    function automatic void rebuild_generator(logic [RSE_CFG_W-1:0] val);
        logic [7:0] c [0:RSE_MAX_PARITY_DEF];
        logic [7:0] root;
        if (val == '0) parity_n = 1;
        else if (int'(val) > RSE_MAX_PARITY_DEF) parity_n = RSE_MAX_PARITY_DEF;
        else parity_n = int'(val);
        for (int k = 0; k <= RSE_MAX_PARITY_DEF; k++) c[k] = 8'h00;
        c[0] = 8'h01;
        root = 8'h01;
        for (int len = 1; len <= parity_n; len++) begin
            c[len] = field_mul(root, c[len-1]);
            for (int k = len - 1; k >= 1; k--) c[k] ^= field_mul(root, c[k-1]);
            root = field_mul(root, 8'h02);
        end
        for (int k = 0; k < RSE_MAX_PARITY_DEF; k++)
            gen_taps[k] = (k < parity_n) ? c[k+1] : 8'h00;
    endfunction

    // Append one predicted beat at the tail of the queue.
    function automatic void queue_beat(t_enc_beat beat);
        expected_beats.insert(expected_beats.size(), beat);
    endfunction

    function automatic void encode_symbol(logic [7:0] sym, logic last);
        logic [7:0] fb;
        t_enc_beat  beat;
        if (byte_count < int'(RSE_FIELD_ORDER)) byte_count++;
        if (byte_count > int'(RSE_FIELD_ORDER) - parity_n) overlong_flag = 1'b1;
        fb = sym ^ rem_syms[0];
        for (int j = 0; j + 1 < parity_n; j++)
            rem_syms[j] = rem_syms[j+1] ^ field_mul(fb, gen_taps[j]);
        rem_syms[parity_n-1] = field_mul(fb, gen_taps[parity_n-1]);
        beat.sym      = sym;
        beat.parity   = 1'b0;
        beat.last     = 1'b0;
        beat.overlong = overlong_flag;
        queue_beat(beat);
        if (last) begin
            for (int j = 0; j < parity_n; j++) begin
                beat.sym      = rem_syms[j];
                beat.parity   = 1'b1;
                beat.last     = (j == parity_n - 1);
                beat.overlong = overlong_flag;
                queue_beat(beat);
            end
            clear_block_state();
        end
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Send one byte; returns at the edge where the beat is taken.
    task automatic send_byte(logic [7:0] sym, logic last);
        int gap;
        gap = draw_gap(tx_steady);
        if (gap > 0) begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_ch.valid     <= 1'b1;
        data_ch.data_byte <= sym;
        data_ch.block_end <= last;
        do @(posedge clk); while (!in_beat);
        encode_symbol(sym, last);
    endtask

    task automatic wait_drained();
        data_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_beats.size() != 0);
    endtask

    task automatic write_parity(logic [RSE_CFG_W-1:0] val);
        wait_drained();
        // let the last parity beat leave the pipeline
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        rebuild_generator(val);
        clear_block_state();
    endtask

    task automatic test_directed();
        // default parity count after reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        // zero means one parity symbol
        write_parity('0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // above the maximum saturates
        write_parity('1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        // write in the middle of a block restarts it
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        write_parity(6'd32);
        send_byte(8'h56, 1'b1);
        write_parity(6'd1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Maximum parity leaves the shortest legal length; run past it.
    task automatic test_long_block();
        int len;
        write_parity(6'd32);
        len = $urandom_range(226, 236);
        for (int i = 0; i < len; i++) begin
            if (i % 40 == 0) begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic test_random_blocks(int target);
        int sent;
        int len;
        bit cut;
        logic [RSE_CFG_W-1:0] val;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 7))
                    0: val = '0;
                    1: val = '1;
                    2: val = RSE_CFG_W'($urandom_range(0, 63));
                    default: val = RSE_CFG_W'($urandom_range(1, 32));
                endcase
                write_parity(val);
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            len = $urandom_range(1, 12);
            cut = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(0, 255)), (i == len - 1) && !cut);
                sent++;
            end
            // a block cut short by a parity count write
            if (cut) write_parity(RSE_CFG_W'($urandom_range(0, 63)));
            else if ($urandom_range(0, 4) == 0) wait_drained();
        end
    endtask

    // Receive side: random stalls, check each beat against the oldest prediction.
    initial begin
        int gap;
        t_enc_beat want;
        forever begin
            gap = draw_gap(rx_steady);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_beat);
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual %h", $time,
                         res_ch.out_byte);
                error_count++;
            end else begin
                want = expected_beats.pop_front();
                compare_field("out_byte", want.sym, res_ch.out_byte);
                compare_field("is_parity", 8'(want.parity), 8'(res_ch.is_parity));
                compare_field("run_last", 8'(want.last), 8'(res_ch.run_last));
                compare_field("too_long", 8'(want.overlong), 8'(res_ch.too_long));
            end
        end
    end

    always @(posedge clk) begin
        if (in_beat || out_beat) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        data_ch.valid     <= 1'b0;
        data_ch.data_byte <= '0;
        data_ch.block_end <= 1'b0;
        rebuild_generator(RSE_RESET_PARITY);
        clear_block_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_block();
        test_random_blocks(120);

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/rse_pkg.sv
sv/rse_in_if.sv
sv/rse_out_if.sv
sv/rse_gen.sv
sv/rse_lfsr.sv
sv/rse_out.sv
sv/reed_solomon_encoder_unit.sv
sv/rse_chk.sv
tb/tb.sv
